// ----- rtl/mfb_pkg.sv -----
`timescale 1ns / 1ps
// shared constants, types and codes for the mono frame buffer
package mfb_pkg;

	localparam int MAX_WIDTH_BYTES = 16;
	localparam int MAX_ROWS        = 64;
	localparam int BANK_BYTES      = MAX_WIDTH_BYTES * MAX_ROWS;
	localparam int OFS_W           = $clog2(BANK_BYTES);
	localparam int ADDR_W          = OFS_W + 1;
	localparam int DEPTH           = 2 * BANK_BYTES;
	localparam int CNT_W           = $clog2(BANK_BYTES + 1);
	localparam int ROW_W           = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

	localparam int WB_W    = 5;
	localparam int HR_W    = 7;
	localparam int CFG_W   = 7;
	localparam int CIDX_W  = 2;
	localparam int COORD_W = 16;

	localparam logic [CIDX_W-1:0] REG_WIDTH_BYTES = 2'd0;
	localparam logic [CIDX_W-1:0] REG_HEIGHT_ROWS = 2'd1;
	localparam logic [CIDX_W-1:0] REG_DOUBLE_BUF  = 2'd2;

	typedef enum logic [2:0] {
		OP_BLACK = 3'd0,
		OP_WHITE = 3'd1,
		OP_FLIP  = 3'd2,
		OP_READ  = 3'd3,
		OP_SWAP  = 3'd4,
		OP_CLEAR = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_INIT,
		ST_IDLE,
		ST_RMW,
		ST_CLEAR
	} state_t;

	// decoded pixel command
	typedef struct packed {
		logic             ok;
		logic [OFS_W-1:0] ofs;
		logic [2:0]       bit_sel;
		logic [CNT_W-1:0] clr_len;
	} cmd_t;

endpackage

// ----- rtl/mfb_ram.sv -----
`timescale 1ns / 1ps
// single-port-write, single-port-read byte store with registered read data
module mfb_ram #(
	parameter int DATA_W = 8,
	parameter int ADDR_W = 11
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/mfb_decode.sv -----
`timescale 1ns / 1ps
// range check, byte offset and clear length from coordinates and geometry
module mfb_decode
	import mfb_pkg::*;
(
	input  logic [WB_W-1:0]    width_bytes,
	input  logic [HR_W-1:0]    height_rows,
	input  logic [COORD_W-1:0] x_coord,
	input  logic [COORD_W-1:0] y_coord,
	output cmd_t               cmd
);

	logic [WB_W-1:0] w_eff;
	logic [HR_W-1:0] h_eff;
	logic            x_ok;
	logic            y_ok;
	logic [15:0]     row_ofs;
	logic [15:0]     area;

	always_comb begin
		w_eff = (32'(width_bytes) > MAX_WIDTH_BYTES) ? WB_W'(MAX_WIDTH_BYTES) : width_bytes;
		h_eff = (32'(height_rows) > MAX_ROWS) ? HR_W'(MAX_ROWS) : height_rows;
		// negative coordinates fail on the sign bit
		x_ok = !x_coord[COORD_W-1] && (x_coord[COORD_W-2:0] < 15'({w_eff, 3'b000}));
		y_ok = !y_coord[COORD_W-1] && (y_coord[COORD_W-2:0] < 15'(h_eff));
		row_ofs = 16'(y_coord[ROW_W-1:0]) * 16'(w_eff);
		area    = 16'(w_eff) * 16'(h_eff);
		cmd.ok      = x_ok && y_ok;
		cmd.ofs     = OFS_W'(row_ofs + 16'(x_coord[COORD_W-2:3]));
		cmd.bit_sel = x_coord[2:0];
		cmd.clr_len = (32'(area) > BANK_BYTES) ? CNT_W'(BANK_BYTES) : CNT_W'(area);
	end

endmodule

// ----- rtl/mono_framebuffer_pixel_unit.sv -----
`timescale 1ns / 1ps
// top level of the one-bit-per-pixel frame buffer with optional second bank
// results: done, pixel_value and in_range are registered from the read-modify-write state or the last clear step
// pixel, swap and unknown ops go through the read-modify-write state; busy holds off a new transaction until it ends
// clear: busy while width*height bytes of the front bank are zeroed, one byte per cycle
// reset: async, active low; then a sweep zeroes both banks with busy high
// results cannot be stalled; configuration writes are taken at any edge
module mono_framebuffer_pixel_unit
	import mfb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         opcode,
	input  logic [COORD_W-1:0] x_coord,
	input  logic [COORD_W-1:0] y_coord,
	output logic               done,
	output logic               pixel_value,
	output logic               in_range,
	input  logic               cfg_we,
	input  logic [CIDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]   cfg_data
);

	// configuration registers
	logic [WB_W-1:0] width_bytes_q;
	logic [HR_W-1:0] height_rows_q;
	logic            double_buf_q;

	// control state
	state_t            state_q, state_d;
	logic              front_q;
	logic [ADDR_W-1:0] init_cnt_q;
	logic [CNT_W-1:0]  clr_cnt_q;

	// transaction held across the read-modify-write
	op_t               op_s1;
	logic              ok_s1;
	logic [2:0]        bit_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [CNT_W-1:0]  clr_len_s1;

	// result registers
	logic done_q, pixel_value_q, in_range_q;

	cmd_t              cmd;
	logic              accept;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [7:0]        ram_wdata;
	logic [7:0]        ram_rdata;
	logic [7:0]        bit_mask;
	logic              res_vld, res_pix, res_rng;
	logic              flip_bank;
	logic              clr_last;

	mfb_decode u_decode (
		.width_bytes (width_bytes_q),
		.height_rows (height_rows_q),
		.x_coord     (x_coord),
		.y_coord     (y_coord),
		.cmd         (cmd)
	);

	// read is launched in the accept cycle so the byte is back in the next one
	mfb_ram #(
		.DATA_W (8),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr ({front_q, cmd.ofs}),
		.rdata (ram_rdata)
	);

	assign accept   = start && !busy;
	assign bit_mask = 8'(1) << bit_s1;
	// last step of a clear: counter has reached len-1, or nothing to clear
	assign clr_last = ((CNT_W+1)'(clr_cnt_q) + (CNT_W+1)'(1)) >= (CNT_W+1)'(clr_len_s1);

	// configuration writes, index beyond the list is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_bytes_q <= WB_W'(16);
			height_rows_q <= HR_W'(64);
			double_buf_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH_BYTES: width_bytes_q <= cfg_data[WB_W-1:0];
				REG_HEIGHT_ROWS: height_rows_q <= cfg_data[HR_W-1:0];
				REG_DOUBLE_BUF:  double_buf_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d   = state_q;
		busy      = 1'b1;
		ram_we    = 1'b0;
		ram_waddr = addr_s1;
		ram_wdata = ram_rdata;
		res_vld   = 1'b0;
		res_pix   = 1'b0;
		res_rng   = 1'b0;
		flip_bank = 1'b0;
		case (state_q)
			ST_INIT: begin
				// sweep both banks to zero after reset
				ram_we    = 1'b1;
				ram_waddr = init_cnt_q;
				ram_wdata = 8'h00;
				if (init_cnt_q == ADDR_W'(DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					state_d = (op_t'(opcode) == OP_CLEAR) ? ST_CLEAR : ST_RMW;
				end
			end
			ST_RMW: begin
				res_vld = 1'b1;
				case (op_s1)
					OP_BLACK: begin
						ram_we    = ok_s1;
						ram_wdata = ram_rdata | bit_mask;
						res_rng   = ok_s1;
					end
					OP_WHITE: begin
						ram_we    = ok_s1;
						ram_wdata = ram_rdata & ~bit_mask;
						res_rng   = ok_s1;
					end
					OP_FLIP: begin
						ram_we    = ok_s1;
						ram_wdata = ram_rdata ^ bit_mask;
						res_rng   = ok_s1;
					end
					OP_READ: begin
						res_pix = ok_s1 && ram_rdata[bit_s1];
						res_rng = ok_s1;
					end
					OP_SWAP: begin
						flip_bank = double_buf_q;
					end
					default: ;
				endcase
				state_d = ST_IDLE;
			end
			ST_CLEAR: begin
				ram_we    = (clr_cnt_q < clr_len_s1);
				ram_waddr = {front_q, clr_cnt_q[OFS_W-1:0]};
				ram_wdata = 8'h00;
				if (clr_last) begin
					res_vld = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_INIT;
			front_q       <= 1'b0;
			init_cnt_q    <= '0;
			clr_cnt_q     <= '0;
			done_q        <= 1'b0;
			pixel_value_q <= 1'b0;
			in_range_q    <= 1'b0;
		end else begin
			state_q       <= state_d;
			done_q        <= res_vld;
			pixel_value_q <= res_pix;
			in_range_q    <= res_rng;
			if (flip_bank) begin
				front_q <= ~front_q;
			end
			if (state_q == ST_INIT) begin
				init_cnt_q <= init_cnt_q + ADDR_W'(1);
			end
			if (accept) begin
				clr_cnt_q <= '0;
			end else if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + CNT_W'(1);
			end
		end
	end

	// transaction payload, captured on accept for the read-modify-write or clear
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1      <= op_t'(opcode);
			ok_s1      <= cmd.ok;
			bit_s1     <= cmd.bit_sel;
			addr_s1    <= {front_q, cmd.ofs};
			clr_len_s1 <= cmd.clr_len;
		end
	end

	assign done        = done_q;
	assign pixel_value = pixel_value_q;
	assign in_range    = in_range_q;

`ifndef NO_ASSERTIONS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy low right after an accepted transaction");

	a_done_follows_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without work in the previous cycle");

	a_fields_need_done: assert property (@(posedge clk) disable iff (!arst_n)
		(pixel_value || in_range) |-> done)
		else $error("result field set without strobe");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !ram_we)
		else $error("memory written while idle");
`endif

endmodule
